### rtl/rfvs_pkg.sv
// ----------------------------------------------------------------------------
// rfvs_pkg
// Shared widths, item codes and the scan control bundle for the
// recency/frequency victim selector.
// ----------------------------------------------------------------------------
package rfvs_pkg;

  localparam int TsW      = 32;  // timestamp and access clock width
  localparam int CntW     = 16;  // use count and ceiling width
  localparam int FuncW    = 2;
  localparam int SetW     = 10;
  localparam int WayInW   = 4;
  localparam int VictimW  = 4;
  localparam int EntryW   = TsW + CntW;

  localparam int NumSetsDefault = 1024;
  localparam int NumWaysDefault = 16;

  localparam logic [CntW-1:0] MaxFreqReset = 16'd1000;

  localparam logic [FuncW-1:0] FuncQuery  = 2'd0;
  localparam logic [FuncW-1:0] FuncFill   = 2'd1;
  localparam logic [FuncW-1:0] FuncAccess = 2'd2;

  // Control travelling with each way read during a victim scan.
  typedef struct packed {
    logic clr;   // start of a new scan: forget the running best
    logic vld;   // read data of one way is on the memory output
    logic last;  // that way is the last of the set
  } scan_ctl_t;

endpackage

### rtl/rfvs_ram.sv
// ----------------------------------------------------------------------------
// rfvs_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rfvs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rfvs_scan.sv
// ----------------------------------------------------------------------------
// rfvs_scan
// Scores one way per cycle and keeps the first way with the highest score.
// ----------------------------------------------------------------------------
module rfvs_scan #(
  parameter int NUM_WAYS = rfvs_pkg::NumWaysDefault,
  localparam int WayW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rfvs_pkg::scan_ctl_t        ctl_i,
  input  logic [WayW-1:0]            way_i,
  input  logic [rfvs_pkg::TsW-1:0]   last_use_i,
  input  logic [rfvs_pkg::CntW-1:0]  count_i,
  input  logic [rfvs_pkg::TsW-1:0]   clock_i,
  input  logic [rfvs_pkg::CntW-1:0]  max_freq_i,
  output logic                       fin_o,
  output logic [WayW-1:0]            victim_o
);

  localparam int TsW = rfvs_pkg::TsW;
  localparam int CntW = rfvs_pkg::CntW;
  localparam int ScW = TsW + 1;

  logic [TsW-1:0]  age;
  logic [CntW-1:0] fterm;
  logic [ScW-1:0]  score_d, score_q;
  logic            sc_vld_q, sc_last_q;
  logic [WayW-1:0] sc_way_q;
  logic [ScW-1:0]  best_q;
  logic [WayW-1:0] best_way_q;
  logic            better;

  // Age wraps modulo 2^32; a count above the ceiling adds nothing.
  assign age     = clock_i - last_use_i;
  assign fterm   = (count_i <= max_freq_i) ? (max_freq_i - count_i) : '0;
  assign score_d = {1'b0, age} + ScW'(fterm);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_vld_q  <= 1'b0;
      sc_last_q <= 1'b0;
    end else begin
      sc_vld_q  <= ctl_i.vld;
      sc_last_q <= ctl_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      score_q  <= score_d;
      sc_way_q <= way_i;
    end
  end

  assign better = sc_vld_q && (score_q > best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q     <= '0;
      best_way_q <= '0;
    end else if (ctl_i.clr) begin
      best_q     <= '0;
      best_way_q <= '0;
    end else if (better) begin
      best_q     <= score_q;
      best_way_q <= sc_way_q;
    end
  end

  assign fin_o    = sc_vld_q && sc_last_q;
  assign victim_o = better ? sc_way_q : best_way_q;

endmodule

### rtl/recency_frequency_victim_select.sv
// ----------------------------------------------------------------------------
// recency_frequency_victim_select
// Hybrid recency/frequency replacement policy for a set-associative cache.
// ----------------------------------------------------------------------------
//
// Channel   | Ports                                         | Transfer when
// ----------+-----------------------------------------------+------------------
// command   | start, busy, func_i, set_index_i, way_index_i, | start && !busy
//           | was_hit_i, is_write_i                          |
// result    | done_o, evict_way_o                            | done_o (no stall)
// config    | cfg_we_i, cfg_wdata_i (frequency ceiling)      | cfg_we_i
//
// A fill writes its entry without raising busy, an access update reads and
// then writes back, and a victim query does one read per way through the
// single read port of the entry memory, then scores the last way and picks the
// victim. The result of a query shows on done_o in the cycle that busy drops.
// After reset a clearing pass writes zeros to all NUM_SETS * NUM_WAYS entries,
// one per cycle, with busy high. The receiver cannot stall; every result is a
// one-cycle strobe.
//
module recency_frequency_victim_select #(
  parameter int NUM_SETS = rfvs_pkg::NumSetsDefault,
  parameter int NUM_WAYS = rfvs_pkg::NumWaysDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [rfvs_pkg::FuncW-1:0]    func_i,
  input  logic [rfvs_pkg::SetW-1:0]     set_index_i,
  input  logic [rfvs_pkg::WayInW-1:0]   way_index_i,
  input  logic                          was_hit_i,
  input  logic                          is_write_i,
  output logic                          done_o,
  output logic [rfvs_pkg::VictimW-1:0]  evict_way_o,
  input  logic                          cfg_we_i,
  input  logic [rfvs_pkg::CntW-1:0]     cfg_wdata_i
);

  localparam int TsW   = rfvs_pkg::TsW;
  localparam int CntW  = rfvs_pkg::CntW;
  localparam int VicW  = rfvs_pkg::VictimW;
  localparam int Depth = NUM_SETS * NUM_WAYS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int WW    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int IW    = $clog2(NUM_WAYS + 1);
  localparam logic [31:0] NumSetsU = 32'(NUM_SETS);
  localparam logic [31:0] NumWaysU = 32'(NUM_WAYS);

  // Controller states.
  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StScan  = 2'd2;
  localparam logic [1:0] StUpd   = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [TsW-1:0]  clock_q, clock_d;
  logic [CntW-1:0] maxf_q;
  logic [IW-1:0]   iss_q, iss_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic            rd_vld_q, rd_vld_d;
  logic            rd_last_q, rd_last_d;
  logic [WW-1:0]   rd_way_q, rd_way_d;
  logic            done_q, done_d;
  logic [VicW-1:0] victim_q, victim_d;

  logic                            accept;
  logic                            set_ok, way_ok;
  logic [31:0]                     set_base, entry;
  logic                            mem_we, mem_re;
  logic [AW-1:0]                   mem_waddr, mem_raddr;
  logic [rfvs_pkg::EntryW-1:0]     mem_wdata, mem_rdata;
  logic [TsW-1:0]                  rd_last_use;
  logic [CntW-1:0]                 rd_count, new_count;
  logic                            scan_clr;
  rfvs_pkg::scan_ctl_t             scan_ctl;
  logic                            scan_fin;
  logic [WW-1:0]                   scan_victim;

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;

  // Entry address is set * NUM_WAYS + way; the range checks keep it in bounds.
  assign set_ok   = 32'(set_index_i) < NumSetsU;
  assign way_ok   = 32'(way_index_i) < NumWaysU;
  assign set_base = 32'(set_index_i) * NumWaysU;
  assign entry    = set_base + 32'(way_index_i);

  assign rd_last_use = mem_rdata[rfvs_pkg::EntryW-1:CntW];
  assign rd_count    = mem_rdata[CntW-1:0];
  // A read hit bumps the count only while it is below the ceiling.
  assign new_count   = (rd_count < maxf_q) ? (rd_count + 1'b1) : rd_count;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    clock_d   = clock_q;
    iss_d     = iss_q;
    addr_d    = addr_q;
    rd_vld_d  = 1'b0;
    rd_last_d = 1'b0;
    rd_way_d  = rd_way_q;
    done_d    = 1'b0;
    victim_d  = victim_q;
    scan_clr  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = addr_q;

    unique case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == AW'(Depth - 1)) begin
          state_d = StIdle;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      StIdle: begin
        if (accept) begin
          unique case (func_i)
            rfvs_pkg::FuncQuery: begin
              if (set_ok) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(set_base);
                addr_d    = AW'(set_base);
                scan_clr  = 1'b1;
                rd_vld_d  = 1'b1;
                rd_way_d  = '0;
                rd_last_d = (NUM_WAYS == 1);
                iss_d     = IW'(1);
                state_d   = StScan;
              end else begin
                // A set beyond the cache answers with way zero at once.
                done_d   = 1'b1;
                victim_d = '0;
              end
            end
            rfvs_pkg::FuncFill: begin
              if (set_ok && way_ok) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(entry);
                mem_wdata = {clock_q, CntW'(1)};
                clock_d   = clock_q + 1'b1;
              end
            end
            rfvs_pkg::FuncAccess: begin
              if (set_ok && way_ok && was_hit_i && !is_write_i) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(entry);
                addr_d    = AW'(entry);
                state_d   = StUpd;
              end
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        if (iss_q != IW'(NUM_WAYS)) begin
          mem_re    = 1'b1;
          mem_raddr = addr_q + AW'(iss_q);
          rd_vld_d  = 1'b1;
          rd_way_d  = WW'(iss_q);
          rd_last_d = (iss_q == IW'(NUM_WAYS - 1));
          iss_d     = iss_q + 1'b1;
        end
        if (scan_fin) begin
          done_d   = 1'b1;
          victim_d = VicW'(scan_victim);
          state_d  = StIdle;
        end
      end
      StUpd: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = {clock_q, new_count};
        clock_d   = clock_q + 1'b1;
        state_d   = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_q     <= '0;
      clock_q   <= '0;
      maxf_q    <= rfvs_pkg::MaxFreqReset;
      iss_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      clock_q   <= clock_d;
      iss_q     <= iss_d;
      rd_vld_q  <= rd_vld_d;
      rd_last_q <= rd_last_d;
      done_q    <= done_d;
      if (cfg_we_i) begin
        maxf_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    rd_way_q <= rd_way_d;
    victim_q <= victim_d;
  end

  // Each entry holds the last-use stamp above the use count.
  rfvs_ram #(
    .Width (rfvs_pkg::EntryW),
    .Depth (Depth)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign scan_ctl.clr  = scan_clr;
  assign scan_ctl.vld  = rd_vld_q;
  assign scan_ctl.last = rd_last_q;

  rfvs_scan #(
    .NUM_WAYS (NUM_WAYS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .way_i      (rd_way_q),
    .last_use_i (rd_last_use),
    .count_i    (rd_count),
    .clock_i    (clock_q),
    .max_freq_i (maxf_q),
    .fin_o      (scan_fin),
    .victim_o   (scan_victim)
  );

  assign done_o      = done_q;
  assign evict_way_o = victim_q;

  // The write-back of an access update always follows its own accepted read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StUpd) |-> $past(accept))
    else $error("update write-back without a preceding accepted access");

  // The access clock moves only by one and only together with a memory write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clock_q != $past(clock_q)) |->
      ((clock_q == $past(clock_q) + 1'b1) && $past(mem_we)))
    else $error("access clock moved without a stamped entry");

  // A result is always presented with the block ready for the next command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  // Scan data only arrives while a query is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == StScan))
    else $error("scan read data outside a query");

endmodule
